// ----- sv/ecspwm_pkg.sv -----
`default_nettype none
package ecspwm_pkg;

  localparam int CLOCK_DIVIDE = 16;
  localparam int CHANNELS     = 8;

  localparam int PRESCALE_W = (CLOCK_DIVIDE > 1) ? $clog2(CLOCK_DIVIDE) : 1;
  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int COUNT_W  = 16;
  localparam int WIDTH_W  = 13;
  localparam int US_W     = 16;
  localparam int CHAN_W   = 4;
  localparam int LEVELS_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam logic [COUNT_W-1:0] PERIOD_RESET    = 16'd31250;
  localparam logic [WIDTH_W-1:0] WIDTH_MIN_RESET = 13'd1000;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX_RESET = 13'd2000;
  localparam logic [COUNT_W-1:0] COMPARE_RESET   = 16'd12500;

  typedef enum logic {
    REQ_TICK  = 1'b0,
    REQ_WRITE = 1'b1
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PERIOD    = 2'd0,
    CFG_WIDTH_MIN = 2'd1,
    CFG_WIDTH_MAX = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic               advance;
    logic               zero;
    logic [COUNT_W-1:0] count_next;
  } tb_evt_t;

  typedef struct packed {
    logic                   en;
    logic [CH_IDX_W-1:0]    ch;
    logic signed [US_W-1:0] width_us;
  } wr_req_t;

endpackage
`default_nettype wire

// ----- sv/ecspwm_timebase.sv -----
`default_nettype none
module ecspwm_timebase (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              tick,
  input  wire logic [ecspwm_pkg::COUNT_W-1:0]    period_counts,
  output ecspwm_pkg::tb_evt_t                    evt
);

  logic [ecspwm_pkg::PRESCALE_W-1:0] prescale;
  logic [ecspwm_pkg::PRESCALE_W-1:0] prescale_next;
  logic [ecspwm_pkg::COUNT_W-1:0]    count;

  always_comb begin
    evt.advance    = tick &&
      (prescale == ecspwm_pkg::PRESCALE_W'(ecspwm_pkg::CLOCK_DIVIDE - 1));
    prescale_next  = prescale;
    evt.count_next = count;
    if (tick) begin
      if (evt.advance) begin
        prescale_next = '0;
      end else begin
        prescale_next = prescale + ecspwm_pkg::PRESCALE_W'(1);
      end
    end
    if (evt.advance) begin
      if (count >= period_counts) begin
        evt.count_next = '0;
      end else begin
        evt.count_next = count + ecspwm_pkg::COUNT_W'(1);
      end
    end
    evt.zero = evt.advance && (evt.count_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale <= '0;
      count    <= '0;
    end else begin
      prescale <= prescale_next;
      count    <= evt.count_next;
    end
  end

endmodule
`default_nettype wire

// ----- sv/ecspwm_channels.sv -----
`default_nettype none
module ecspwm_channels (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire ecspwm_pkg::wr_req_t               wr,
  input  wire logic [ecspwm_pkg::WIDTH_W-1:0]    width_min,
  input  wire logic [ecspwm_pkg::WIDTH_W-1:0]    width_max,
  input  wire ecspwm_pkg::tb_evt_t               evt,
  output logic [ecspwm_pkg::LEVELS_W-1:0]        levels_next
);

  logic [ecspwm_pkg::COUNT_W-1:0] shadow [ecspwm_pkg::CHANNELS];
  logic [ecspwm_pkg::COUNT_W-1:0] active [ecspwm_pkg::CHANNELS];
  logic [ecspwm_pkg::COUNT_W-1:0] active_next [ecspwm_pkg::CHANNELS];
  logic [ecspwm_pkg::CHANNELS-1:0] levels;
  logic [ecspwm_pkg::CHANNELS-1:0] lv_next;

  logic signed [ecspwm_pkg::US_W-1:0]    min_s;
  logic signed [ecspwm_pkg::US_W-1:0]    max_s;
  logic signed [ecspwm_pkg::US_W-1:0]    clamped;
  logic [17:0]                           product;
  logic [ecspwm_pkg::COUNT_W-1:0]        scaled;

  // clamp low then high, then times 12.5 as (w*25)>>1 with saturation
  always_comb begin
    min_s   = signed'({3'b000, width_min});
    max_s   = signed'({3'b000, width_max});
    clamped = wr.width_us;
    if (clamped < min_s) begin
      clamped = min_s;
    end
    if (clamped > max_s) begin
      clamped = max_s;
    end
    product = {1'b0, clamped[12:0], 4'b0000} + {2'b00, clamped[12:0], 3'b000}
            + {5'b00000, clamped[12:0]};
    if (product[17]) begin
      scaled = '1;
    end else begin
      scaled = product[16:1];
    end
  end

  always_comb begin
    for (int n = 0; n < ecspwm_pkg::CHANNELS; n++) begin
      active_next[n] = evt.zero ? shadow[n] : active[n];
      lv_next[n]     = evt.zero ? 1'b1 : levels[n];
      if (evt.advance && (active_next[n] == evt.count_next)) begin
        lv_next[n] = 1'b0;
      end
    end
    levels_next = ecspwm_pkg::LEVELS_W'(lv_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      levels <= '0;
      for (int n = 0; n < ecspwm_pkg::CHANNELS; n++) begin
        shadow[n] <= ecspwm_pkg::COMPARE_RESET;
        active[n] <= ecspwm_pkg::COMPARE_RESET;
      end
    end else begin
      levels <= lv_next;
      for (int n = 0; n < ecspwm_pkg::CHANNELS; n++) begin
        active[n] <= active_next[n];
        if (wr.en && (wr.ch == ecspwm_pkg::CH_IDX_W'(n))) begin
          shadow[n] <= scaled;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/eight_channel_shadowed_pwm_top.sv -----
// an accepted input word goes through the input word register, then the result word register, to m_t*
// throughput: one word per cycle, bounded only by m_tready
// the per-item step is one pass through the timebase and channel compare logic
// reset (rst, synchronous, active high) empties both stages, zeroes prescaler,
// timebase and output levels, sets compares to 12500 and registers to defaults
`default_nettype none
module eight_channel_shadowed_pwm_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  // [3:0] channel, [19:4] width_us, [23:20] zero
  input  wire logic [ecspwm_pkg::IN_DATA_W-1:0]      s_tdata,
  // [0] req_type
  input  wire logic [0:0]                            s_tuser,
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  // [7:0] pwm_levels, [23:8] count_now
  output logic [ecspwm_pkg::OUT_DATA_W-1:0]          m_tdata,
  // [0] accepted
  output logic [0:0]                                 m_tuser,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [ecspwm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ecspwm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [ecspwm_pkg::COUNT_W-1:0] period_counts;
  logic [ecspwm_pkg::WIDTH_W-1:0] width_min;
  logic [ecspwm_pkg::WIDTH_W-1:0] width_max;

  logic                              in_valid;
  ecspwm_pkg::req_t                  in_type;
  logic [ecspwm_pkg::CHAN_W-1:0]     in_channel;
  logic signed [ecspwm_pkg::US_W-1:0] in_width;

  logic                              out_valid;
  logic                              out_accepted;
  logic [ecspwm_pkg::LEVELS_W-1:0]   out_levels;
  logic [ecspwm_pkg::COUNT_W-1:0]    out_count;

  logic                              fire;
  logic                              chan_ok;
  ecspwm_pkg::wr_req_t               wr;
  ecspwm_pkg::tb_evt_t               evt;
  logic [ecspwm_pkg::LEVELS_W-1:0]   levels_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_counts <= ecspwm_pkg::PERIOD_RESET;
      width_min     <= ecspwm_pkg::WIDTH_MIN_RESET;
      width_max     <= ecspwm_pkg::WIDTH_MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ecspwm_pkg::cfg_idx_t'(cfg_index))
        ecspwm_pkg::CFG_PERIOD: begin
          period_counts <= cfg_data;
        end
        ecspwm_pkg::CFG_WIDTH_MIN: begin
          width_min <= cfg_data[ecspwm_pkg::WIDTH_W-1:0];
        end
        ecspwm_pkg::CFG_WIDTH_MAX: begin
          width_max <= cfg_data[ecspwm_pkg::WIDTH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign fire     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || fire;
  assign chan_ok  = in_channel < ecspwm_pkg::CHAN_W'(ecspwm_pkg::CHANNELS);

  always_comb begin
    wr.en       = fire && (in_type == ecspwm_pkg::REQ_WRITE) && chan_ok;
    wr.ch       = in_channel[ecspwm_pkg::CH_IDX_W-1:0];
    wr.width_us = in_width;
  end

  // input word register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_type    <= ecspwm_pkg::req_t'(s_tuser[0]);
      in_channel <= s_tdata[3:0];
      in_width   <= s_tdata[19:4];
    end
  end

  ecspwm_timebase u_timebase (
    .clk           (clk),
    .rst           (rst),
    .tick          (fire && (in_type == ecspwm_pkg::REQ_TICK)),
    .period_counts (period_counts),
    .evt           (evt)
  );

  ecspwm_channels u_channels (
    .clk         (clk),
    .rst         (rst),
    .wr          (wr),
    .width_min   (width_min),
    .width_max   (width_max),
    .evt         (evt),
    .levels_next (levels_next)
  );

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_accepted <= (in_type == ecspwm_pkg::REQ_TICK) || chan_ok;
      out_levels   <= levels_next;
      out_count    <= evt.count_next;
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = {out_count, out_levels};
  assign m_tuser[0] = out_accepted;

endmodule
`default_nettype wire

// ----- sv/ecspwm_checker.sv -----
`default_nettype none
module ecspwm_checker (
  input wire logic                                  clk,
  input wire logic                                  rst,
  input wire logic                                  s_tvalid,
  input wire logic                                  s_tready,
  input wire logic                                  m_tvalid,
  input wire logic                                  m_tready,
  input wire logic [ecspwm_pkg::OUT_DATA_W-1:0]     m_tdata,
  input wire logic [0:0]                            m_tuser
);

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a draining output never stalls the input side
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output drains");

  // a fresh result comes from a word taken in through the input word register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without matching input word");

endmodule

bind eight_channel_shadowed_pwm_top ecspwm_checker u_ecspwm_checker (.*);
`default_nettype wire

// ----- tb/sv/eight_channel_shadowed_pwm_top_tb.sv -----
`timescale 1ns / 100ps
module eight_channel_shadowed_pwm_top_tb;
  import ecspwm_pkg::*;

  typedef struct packed {
    logic                accepted;
    logic [LEVELS_W-1:0] levels;
    logic [COUNT_W-1:0]  count;
  } pwm_status_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [0:0]            m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predicted block state
  logic [COUNT_W-1:0]    period_m;
  logic [WIDTH_W-1:0]    width_min_m;
  logic [WIDTH_W-1:0]    width_max_m;
  logic [PRESCALE_W-1:0] prescale_m;
  logic [COUNT_W-1:0]    timebase_m;
  logic [COUNT_W-1:0]    shadow_m [CHANNELS];
  logic [COUNT_W-1:0]    active_m [CHANNELS];
  logic [LEVELS_W-1:0]   levels_m;

  pwm_status_t expected_status_q[$];
  pwm_status_t seen_status;
  pwm_status_t due_status;
  int          errors = 0;

  bit tx_offering = 1'b0;
  bit tx_no_gaps = 1'b0;
  int tx_burst_left = 0;

  int          rx_hold_request = 0;
  int          rx_hold_left = 0;
  int          rx_phase_left = 0;
  logic [15:0] rx_pattern = '1;

  eight_channel_shadowed_pwm_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void reset_pwm_model();
    period_m    = PERIOD_RESET;
    width_min_m = WIDTH_MIN_RESET;
    width_max_m = WIDTH_MAX_RESET;
    prescale_m  = '0;
    timebase_m  = '0;
    levels_m    = '0;
    for (int n = 0; n < CHANNELS; n++) begin
      shadow_m[n] = COMPARE_RESET;
      active_m[n] = COMPARE_RESET;
    end
  endfunction

  function automatic logic [COUNT_W-1:0] scaled_compare(logic [US_W-1:0] raw);
    int w;
    int scaled;
    w = $signed(raw);
    if (w < int'(width_min_m)) w = int'(width_min_m);
    if (w > int'(width_max_m)) w = int'(width_max_m);
    scaled = (w * 25) >> 1;
    if (scaled > 65535) scaled = 65535;
    return COUNT_W'(scaled);
  endfunction

  function automatic void advance_timebase_model();
    if (timebase_m >= period_m) timebase_m = '0;
    else timebase_m = timebase_m + 1'b1;
    if (timebase_m == '0) begin
      for (int n = 0; n < CHANNELS; n++) active_m[n] = shadow_m[n];
      levels_m = '1;
    end
    // clear on compare wins over the set at zero
    for (int n = 0; n < CHANNELS; n++) begin
      if (active_m[n] == timebase_m) levels_m[n] = 1'b0;
    end
  endfunction

  function automatic pwm_status_t predict_status(req_t kind, logic [CHAN_W-1:0] ch,
                                                 logic [US_W-1:0] w);
    pwm_status_t r;
    r.accepted = 1'b1;
    if (kind == REQ_TICK) begin
      if (int'(prescale_m) >= CLOCK_DIVIDE - 1) begin
        prescale_m = '0;
        advance_timebase_model();
      end else begin
        prescale_m = prescale_m + 1'b1;
      end
    end else if (int'(ch) < CHANNELS) begin
      shadow_m[ch] = scaled_compare(w);
    end else begin
      r.accepted = 1'b0;
    end
    r.levels = levels_m;
    r.count  = timebase_m;
    return r;
  endfunction

  function automatic void report_mismatch(string what, int unsigned want, int unsigned got);
    errors++;
    if (errors <= 40)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endfunction

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_status.accepted = m_tuser[0];
      seen_status.levels   = m_tdata[LEVELS_W-1:0];
      seen_status.count    = m_tdata[LEVELS_W +: COUNT_W];
      if (expected_status_q.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: word with nothing expected, expected none, actual %0h_%0h", $time,
                   m_tuser, m_tdata);
      end else begin
        due_status = expected_status_q.pop_front();
        if (seen_status.accepted !== due_status.accepted)
          report_mismatch("accepted", due_status.accepted, seen_status.accepted);
        if (seen_status.levels !== due_status.levels)
          report_mismatch("pwm_levels", due_status.levels, seen_status.levels);
        if (seen_status.count !== due_status.count)
          report_mismatch("count_now", due_status.count, seen_status.count);
      end
    end
  end

  // receiver: stall pattern changes every so often, long hold on request
  always @(posedge clk) begin
    if (rx_hold_request != 0) begin
      rx_hold_left = rx_hold_request;
      rx_hold_request = 0;
    end
    if (rx_phase_left == 0) begin
      rx_phase_left = $urandom_range(16, 200);
      case ($urandom_range(0, 3))
        0: rx_pattern = '1;
        1: rx_pattern = 16'($urandom);
        2: rx_pattern = 16'($urandom | $urandom);
        default: rx_pattern = 16'($urandom & $urandom);
      endcase
      if (rx_pattern == '0) rx_pattern = 16'h0001;
    end
    rx_phase_left--;
    rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
    if (rx_hold_left > 0) begin
      m_tready <= 1'b0;
      rx_hold_left--;
    end else begin
      m_tready <= rx_pattern[0];
    end
  end

  task automatic send_word(input req_t kind, input logic [CHAN_W-1:0] ch,
                           input logic [US_W-1:0] w);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{(IN_DATA_W - US_W - CHAN_W){1'b0}}, w, ch};
    tx_offering = 1'b1;
    do @(posedge clk); while (!s_tready);
    expected_status_q.push_back(predict_status(kind, ch, w));
    if (!tx_no_gaps) begin
      if (tx_burst_left > 0) begin
        tx_burst_left--;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          tx_offering = 1'b0;
          repeat (gap) @(posedge clk);
        end
        tx_burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 8);
      end
    end
  endtask

  task automatic send_random_word();
    req_t              kind;
    logic [CHAN_W-1:0] ch;
    logic [US_W-1:0]   w;
    kind = ($urandom_range(0, 99) < 85) ? REQ_TICK : REQ_WRITE;
    ch = ($urandom_range(0, 4) == 0) ? CHAN_W'($urandom_range(8, 15))
                                     : CHAN_W'($urandom_range(0, 7));
    case ($urandom_range(0, 3))
      0: w = US_W'($urandom);
      3: w = US_W'(-int'($urandom_range(1, 4)));
      default: w = US_W'($urandom_range(0, 3));
    endcase
    send_word(kind, ch, w);
  endtask

  task automatic wait_idle();
    if (tx_offering) begin
      s_tvalid <= 1'b0;
      tx_offering = 1'b0;
    end
    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] period,
                              input logic [CFG_DATA_W-1:0] wmin,
                              input logic [CFG_DATA_W-1:0] wmax);
    write_reg(CFG_PERIOD, period);
    write_reg(CFG_WIDTH_MIN, wmin);
    write_reg(CFG_WIDTH_MAX, wmax);
    cfg_valid <= 1'b0;
    period_m    = period;
    width_min_m = wmin[WIDTH_W-1:0];
    width_max_m = wmax[WIDTH_W-1:0];
  endtask

  task automatic test_reset_defaults();
    send_word(REQ_TICK, 4'd0, 16'd0);
    send_word(REQ_WRITE, 4'd0, 16'h8000);
    send_word(REQ_WRITE, 4'd7, 16'h7FFF);
    send_word(REQ_WRITE, 4'd8, 16'd1500);
    send_word(REQ_WRITE, 4'd15, 16'hFFFF);
    send_word(REQ_WRITE, 4'd3, 16'd1500);
  endtask

  task automatic test_zero_period_saturation();
    wait_idle();
    program_regs(16'd0, 16'd0, 16'd8191);
    send_word(REQ_WRITE, 4'd1, 16'h7FFF);
    send_word(REQ_WRITE, 4'd2, 16'h0000);
    repeat (16) send_word(REQ_TICK, 4'hF, 16'hFFFF);
  endtask

  task automatic run_random_phase(input logic [CFG_DATA_W-1:0] period,
                                  input logic [CFG_DATA_W-1:0] wmin,
                                  input logic [CFG_DATA_W-1:0] wmax, input int words);
    wait_idle();
    program_regs(period, wmin, wmax);
    repeat (words) send_random_word();
  endtask

  task automatic test_random_sweep();
    run_random_phase(16'd65535, 16'd5242, 16'd5242, 100);
    // period drops below the running count here
    run_random_phase(16'd0, 16'd0, 16'd1, 100);
    run_random_phase(16'd1, 16'd0, 16'd1, 130);
    run_random_phase(16'd5, 16'd0, 16'd2, 150);
    run_random_phase(16'd13, 16'd0, 16'd1, 250);
    // min above max
    run_random_phase(16'd26, 16'd2, 16'd1, 220);
  endtask

  task automatic test_backpressure();
    wait_idle();
    program_regs(16'd3, 16'd0, 16'd2);
    rx_hold_request = 300;
    tx_no_gaps = 1'b1;
    repeat (60) send_random_word();
    tx_no_gaps = 1'b0;
    wait_idle();
  endtask

  initial begin
    reset_pwm_model();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_zero_period_saturation();
    test_random_sweep();
    test_backpressure();
    wait_idle();
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_status_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- eight_channel_shadowed_pwm_top.f -----
sv/ecspwm_pkg.sv
sv/ecspwm_timebase.sv
sv/ecspwm_channels.sv
sv/eight_channel_shadowed_pwm_top.sv
sv/ecspwm_checker.sv
tb/sv/eight_channel_shadowed_pwm_top_tb.sv
